FILE: src/mns_pkg.sv
// Shared constants and controller/datapath interface types for the mono note stack.
package mns_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int HCNT_W      = 4;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_PRESS   = 1'b1;
    localparam logic ACT_PLAY     = 1'b0;
    localparam logic ACT_STOP     = 1'b1;

    typedef struct packed {
        logic capture;   // latch the accepted input transaction
        logic press;     // append the captured note, dropping the oldest when full
        logic step;      // advance the search pointer
        logic remove;    // remove the entry under the search pointer
        logic load_out;  // load a result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_press;    // captured transaction is a key press
        logic match;       // entry under the search pointer equals the captured note
        logic search_end;  // search pointer has reached the held count
        logic empty;       // no held notes
        logic out_free;    // output register can take a result this cycle
    } t_dp_sts;

endpackage

FILE: src/mns_ctrl.sv
// Controller state machine that sequences press, search, remove and result steps.
module mns_ctrl
    import mns_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PRESS  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SEARCH;
                end
            end
            ST_PRESS: begin
                o_cmd.press = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_SEARCH: begin
                // A press skips the search; a release walks the held entries oldest first.
                priority if (i_sts.is_press) begin
                    n_state = ST_PRESS;
                end else if (i_sts.search_end) begin
                    n_state = ST_FINISH;
                end else if (i_sts.match) begin
                    o_cmd.remove = 1'b1;
                    n_state      = ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_sts.is_press || i_sts.empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/mns_dp.sv
// Datapath: held note list, count, search pointer, captured event and output register.
module mns_dp
    import mns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_kind,
    input  logic [NOTE_W-1:0]     i_note,
    input  logic [VEL_W-1:0]      i_vel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_out_action,
    output logic [NOTE_W-1:0]     o_out_note,
    output logic [VEL_W-1:0]      o_out_vel,
    output logic [HCNT_W-1:0]     o_out_count
);

    logic [NOTE_W-1:0] r_entry [STACK_DEPTH];
    logic [NOTE_W-1:0] n_entry [STACK_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_kind;
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;
    logic              r_out_valid;
    logic              r_out_action;
    logic [NOTE_W-1:0] r_out_note;
    logic [VEL_W-1:0]  r_out_vel;
    logic [HCNT_W-1:0] r_out_count;
    logic              w_full;

    assign w_full = (r_count == CNT_W'(STACK_DEPTH));

    assign o_sts.is_press   = (r_kind == KIND_PRESS);
    assign o_sts.search_end = (r_idx >= r_count);
    // Only meaningful while the pointer is below the count, where it indexes a held entry.
    assign o_sts.match      = (r_entry[r_idx[IDX_W-1:0]] == r_note);
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_entry = r_entry;
        n_count = r_count;
        if (i_cmd.press) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                if (w_full) begin
                    n_entry[i] = (i == STACK_DEPTH - 1) ? r_note : r_entry[(i + 1) % STACK_DEPTH];
                end else if (r_count == CNT_W'(i)) begin
                    n_entry[i] = r_note;
                end
            end
            if (!w_full) begin
                n_count = r_count + 1'b1;
            end
        end else if (i_cmd.remove) begin
            // Close the gap: every entry at or above the match takes its upper neighbor.
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                if (CNT_W'(i) >= r_idx) begin
                    n_entry[i] = r_entry[i + 1];
                end
            end
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_note <= i_note;
            r_vel  <= i_vel;
            r_idx  <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_action <= (r_kind == KIND_PRESS) ? ACT_PLAY : ACT_STOP;
            r_out_note   <= r_note;
            r_out_vel    <= r_vel;
            r_out_count  <= HCNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_action = r_out_action;
    assign o_out_note   = r_out_note;
    assign o_out_vel    = r_out_vel;
    assign o_out_count  = r_out_count;

endmodule

FILE: src/mono_note_stack_unit.sv
// Top level of the monophonic note stack: controller plus datapath.
//
// Usage: key events enter on the slave stream (s_*), results leave on the
// master stream (m_*). tuser on the input is the event kind (1 press,
// 0 release); tuser on the output is the action (0 play, 1 stop).
// A press appends the note (dropping the oldest when the list is full) and
// always produces a play result. A release removes the oldest matching held
// note and produces a stop result only when the list is then empty.
// Timing: the input is taken only while the controller is idle. A press passes
// through the search, press and finish states before its result is loaded; a release
// steps the search pointer past up to STACK_DEPTH held entries, one per cycle, until
// it finds the note or reaches the count, then finishes. The next event is accepted
// once the controller is back in idle.
// Reset empties the list and clears the output valid flag; stored notes are
// not cleared since entries above the count are never read.
// If the receiver stalls, one finished result waits in the output register
// while the next event is still accepted and worked on; if that event produces a
// result, it then waits in its final step until the register is taken.
module mono_note_stack_unit
    import mns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // [6:0] key_note, [13:7] key_velocity
    input  logic                  i_s_tuser,  // [0] kind
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // [6:0] out_note, [13:7] out_velocity,
                                              // [17:14] held_count
    output logic                  o_m_tuser   // [0] action
);

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [NOTE_W-1:0] w_out_note;
    logic [VEL_W-1:0]  w_out_vel;
    logic [HCNT_W-1:0] w_out_count;

    mns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mns_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_s_tuser),
        .i_note       (i_s_tdata[NOTE_W-1:0]),
        .i_vel        (i_s_tdata[NOTE_W+VEL_W-1:NOTE_W]),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_action (o_m_tuser),
        .o_out_note   (w_out_note),
        .o_out_vel    (w_out_vel),
        .o_out_count  (w_out_count)
    );

    assign o_m_tdata = {(OUT_DATA_W - NOTE_W - VEL_W - HCNT_W)'(0), w_out_count, w_out_vel,
                        w_out_note};

endmodule

FILE: src/mns_checker.sv
// Port-level checker for the mono note stack, bound to the top level.
module mns_checker
    import mns_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // The block works on one event at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted in consecutive cycles");

    // A stop is only sent when the list is empty.
    a_stop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ACT_STOP) |-> (o_m_tdata[17:14] == 4'd0))
        else $error("stop result with notes held");

    // A play result always counts the pressed note.
    a_play_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ACT_PLAY) && (STACK_DEPTH < 16)
            |-> (o_m_tdata[17:14] != 4'd0) && (o_m_tdata[17:14] <= 4'(STACK_DEPTH)))
        else $error("play result with bad held count");

endmodule

bind mono_note_stack_unit mns_checker u_mns_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: sim/testbench.sv
// Self-checking testbench for the monophonic note stack: stream stimulus, scoreboard, checks.

module testbench
    import mns_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       action;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] held;
    } t_voice_cmd;

    // Tracks the held-key list and the voice commands that the block owes.
    class note_stack_scoreboard;
        int unsigned held_keys [mns_pkg::STACK_DEPTH];
        int unsigned held_cnt;
        t_voice_cmd  owed_cmds [$];
        int unsigned error_count;

        function new();
            held_cnt    = 0;
            error_count = 0;
        endfunction

        function void drop_key(int unsigned pos);
            for (int unsigned i = pos + 1; i < held_cnt; i++)
                held_keys[i - 1] = held_keys[i];
            held_cnt--;
        endfunction

        // Called for every accepted key event transaction.
        function void note_key_event(logic kind, logic [6:0] note, logic [6:0] velocity);
            t_voice_cmd cmd;
            cmd.note     = note;
            cmd.velocity = velocity;
            if (kind == mns_pkg::KIND_PRESS) begin
                if (held_cnt >= mns_pkg::STACK_DEPTH)
                    drop_key(0);
                held_keys[held_cnt] = note;
                held_cnt++;
                cmd.action = mns_pkg::ACT_PLAY;
                cmd.held   = 4'(held_cnt);
                owed_cmds.push_back(cmd);
            end else begin
                for (int unsigned i = 0; i < held_cnt; i++) begin
                    if (held_keys[i] == note) begin
                        drop_key(i);
                        break;
                    end
                end
                // A release that leaves the list empty stops the voice, matched or not.
                if (held_cnt == 0) begin
                    cmd.action = mns_pkg::ACT_STOP;
                    cmd.held   = 4'd0;
                    owed_cmds.push_back(cmd);
                end
            end
        endfunction

        function void check_voice_cmd(t_voice_cmd got);
            t_voice_cmd want;
            if (owed_cmds.size() == 0) begin
                $display("%0t: unexpected result action=%0d note=%0d vel=%0d held=%0d",
                         $time, got.action, got.note, got.velocity, got.held);
                error_count++;
                return;
            end
            want = owed_cmds.pop_front();
            if (got.action !== want.action) begin
                $display("%0t: action mismatch, expected %0d, actual %0d",
                         $time, want.action, got.action);
                error_count++;
            end
            if (got.note !== want.note) begin
                $display("%0t: note mismatch, expected %0d, actual %0d",
                         $time, want.note, got.note);
                error_count++;
            end
            if (got.velocity !== want.velocity) begin
                $display("%0t: velocity mismatch, expected %0d, actual %0d",
                         $time, want.velocity, got.velocity);
                error_count++;
            end
            if (got.held !== want.held) begin
                $display("%0t: held count mismatch, expected %0d, actual %0d",
                         $time, want.held, got.held);
                error_count++;
            end
        endfunction

        function int unsigned owed_count();
            return owed_cmds.size();
        endfunction
    endclass

    localparam int RANDOM_EVENTS = 1650;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;

    note_stack_scoreboard sb = new();

    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    logic        drain         = 1'b0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned pattern_left  = 0;

    mono_note_stack_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("mono_note_stack_unit test failed");
        $finish;
    end

    // Result side: check each accepted transaction, then choose the next tready.
    always @(posedge i_clk) begin
        t_voice_cmd got;
        logic       rdy;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.action   = o_m_tuser;
            got.note     = o_m_tdata[6:0];
            got.velocity = o_m_tdata[13:7];
            got.held     = o_m_tdata[17:14];
            sb.check_voice_cmd(got);
        end
        if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (drain) begin
            rdy = 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            if (pattern_left == 0) begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                pattern_left  = $urandom_range(64, 256);
            end
            rdy           = stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_left--;
        end
        i_m_tready <= rdy;
    end

    // Offers one key event and returns at the edge where it is accepted.
    task automatic send_key_event(logic kind, logic [6:0] note, logic [6:0] velocity);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {2'b00, velocity, note};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_key_event(kind, note, velocity);
    endtask

    task automatic idle_sender(int unsigned cycles);
        if (cycles > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned press_pct;
        int unsigned burst_left;
        logic        kind;
        logic [6:0]  note;
        logic [6:0]  velocity;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: release on an empty list, extremes, duplicates,
        // pressing into a full list, releasing a note that is not held,
        // and emptying the list from both ends.
        send_key_event(KIND_RELEASE, 7'd60, 7'd33);
        send_key_event(KIND_PRESS, 7'd0, 7'd0);
        send_key_event(KIND_PRESS, 7'd127, 7'd127);
        send_key_event(KIND_PRESS, 7'd64, 7'd1);
        send_key_event(KIND_PRESS, 7'd64, 7'd126);
        send_key_event(KIND_PRESS, 7'd85, 7'd42);
        send_key_event(KIND_PRESS, 7'd42, 7'd85);
        send_key_event(KIND_PRESS, 7'd10, 7'd100);
        send_key_event(KIND_PRESS, 7'd11, 7'd101);
        send_key_event(KIND_PRESS, 7'd12, 7'd102);
        send_key_event(KIND_PRESS, 7'd13, 7'd103);
        send_key_event(KIND_RELEASE, 7'd99, 7'd5);
        send_key_event(KIND_RELEASE, 7'd64, 7'd6);
        send_key_event(KIND_RELEASE, 7'd13, 7'd7);
        send_key_event(KIND_RELEASE, 7'd64, 7'd8);
        send_key_event(KIND_RELEASE, 7'd85, 7'd9);
        send_key_event(KIND_RELEASE, 7'd42, 7'd10);
        send_key_event(KIND_RELEASE, 7'd10, 7'd11);
        send_key_event(KIND_RELEASE, 7'd11, 7'd12);
        send_key_event(KIND_RELEASE, 7'd12, 7'd127);
        send_key_event(KIND_RELEASE, 7'd0, 7'd127);
        wait_for_results();

        // Random part: phases lean toward presses or releases so the list
        // swings between empty and full, and most releases hit a held note.
        press_pct  = 50;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0: press_pct = 25;
                    1: press_pct = 50;
                    2: press_pct = 75;
                    default: press_pct = 90;
                endcase
            end
            if (n == 400 || n == 900 || n == 1400)
                hold_requests <= hold_requests + 1;
            if (n == 650 || n == 1150)
                wait_for_results();

            velocity = 7'($urandom_range(0, 127));
            if ($urandom_range(1, 100) <= press_pct) begin
                kind = KIND_PRESS;
                // A small pool of notes makes duplicate held keys common.
                note = ($urandom_range(0, 1) == 0) ? 7'(60 + $urandom_range(0, 5))
                                                   : 7'($urandom_range(0, 127));
            end else begin
                kind = KIND_RELEASE;
                if (sb.held_cnt > 0 && $urandom_range(0, 3) != 0)
                    note = 7'(sb.held_keys[$urandom_range(0, sb.held_cnt - 1)]);
                else
                    note = 7'($urandom_range(0, 127));
            end
            send_key_event(kind, note, velocity);

            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                idle_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
            end
        end

        wait_for_results();
        drain <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.owed_count() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.owed_count());
            sb.error_count++;
        end

        if (sb.error_count == 0)
            $display("mono_note_stack_unit test passed");
        else
            $display("mono_note_stack_unit test failed");
        $finish;
    end

endmodule
